[hdl/btl_pkg.sv]
// Shared types and constants of the bitmap text layout block.
package btl_pkg;

  // Action codes of an input item
  localparam logic [1:0] ACT_GLYPH_WRITE = 2'd0;
  localparam logic [1:0] ACT_START       = 2'd1;
  localparam logic [1:0] ACT_CHAR        = 2'd2;

  // Configuration register indexes
  localparam logic [2:0] REG_LETTER_SPACING = 3'd0;
  localparam logic [2:0] REG_LINE_SPACING   = 3'd1;
  localparam logic [2:0] REG_LINE_HEIGHT    = 3'd2;
  localparam logic [2:0] REG_DEST_WIDTH     = 3'd3;
  localparam logic [2:0] REG_DEST_HEIGHT    = 3'd4;

  // Character codes
  localparam logic [7:0] CODE_NEWLINE         = 8'd10;
  localparam logic [7:0] CODE_SPACE           = 8'd32;
  localparam logic [7:0] FIRST_PRINTABLE      = 8'd33;
  localparam logic [7:0] LAST_LOW_PRINTABLE   = 8'd126;
  localparam logic [7:0] FIRST_HIGH_PRINTABLE = 8'd161;
  localparam logic [7:0] HIGH_SHIFT           = 8'd34;

  // Work for the pen stage
  typedef enum logic [1:0] {
    KIND_START,
    KIND_NEWLINE,
    KIND_SPACE,
    KIND_GLYPH
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] start_x;
    logic [15:0] start_y;
  } op_t;

endpackage

[hdl/bitmap_text_layout.sv]
// Top level of the bitmap text layout engine.
// Takes one item per clock cycle; an item is accepted whenever in_stall is
// low, which happens unless out_stall holds a finished blit command in the
// output register while another item waits in the pen stage behind it. Each
// item passes two stages: the first decodes it and reads the glyph table (a
// single RAM with a registered read, written in the same stage by glyph
// writes), the second updates the pen and clips. A blit command is loaded into
// the output register from the stage-one register and the registered table
// read, once the pen stage is not held. The
// glyph table reads as zero after reset through per-slot written flags, so
// there is no clearing pass. Configuration registers are written through
// cfg_we, cfg_addr and cfg_wdata.
module bitmap_text_layout #(
  parameter int GLYPH_SLOTS = 256
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_addr,
  input  logic [11:0]         cfg_wdata,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          action,
  input  logic [7:0]          glyph_index,
  input  logic [11:0]         strip_x,
  input  logic [7:0]          strip_width,
  input  logic signed [15:0]  start_x,
  input  logic signed [15:0]  start_y,
  input  logic [7:0]          char_code,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [11:0]         source_x,
  output logic [7:0]          copy_width,
  output logic signed [15:0]  dest_x,
  output logic signed [15:0]  dest_y
);

  logic [7:0]   letter_spacing;
  logic [7:0]   line_spacing;
  logic [7:0]   line_height;
  logic [11:0]  dest_width;
  logic [11:0]  dest_height;
  logic         hold;
  logic         s1_valid;
  btl_pkg::op_t s1_op;
  logic [11:0]  glyph_pos;
  logic [7:0]   glyph_width;

  always_ff @(posedge clk) begin
    if (rst) begin
      letter_spacing <= '0;
      line_spacing   <= '0;
      line_height    <= '0;
      dest_width     <= '0;
      dest_height    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        btl_pkg::REG_LETTER_SPACING: letter_spacing <= cfg_wdata[7:0];
        btl_pkg::REG_LINE_SPACING:   line_spacing   <= cfg_wdata[7:0];
        btl_pkg::REG_LINE_HEIGHT:    line_height    <= cfg_wdata[7:0];
        btl_pkg::REG_DEST_WIDTH:     dest_width     <= cfg_wdata;
        btl_pkg::REG_DEST_HEIGHT:    dest_height    <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  btl_fetch #(
    .GLYPH_SLOTS(GLYPH_SLOTS)
  ) u_fetch (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .action     (action),
    .glyph_index(glyph_index),
    .strip_x    (strip_x),
    .strip_width(strip_width),
    .start_x    (start_x),
    .start_y    (start_y),
    .char_code  (char_code),
    .hold       (hold),
    .s1_valid   (s1_valid),
    .s1_op      (s1_op),
    .glyph_pos  (glyph_pos),
    .glyph_width(glyph_width)
  );

  btl_pen u_pen (
    .clk           (clk),
    .rst           (rst),
    .s1_valid      (s1_valid),
    .s1_op         (s1_op),
    .glyph_pos     (glyph_pos),
    .glyph_width   (glyph_width),
    .letter_spacing(letter_spacing),
    .line_spacing  (line_spacing),
    .line_height   (line_height),
    .dest_width    (dest_width),
    .dest_height   (dest_height),
    .hold          (hold),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .source_x      (source_x),
    .copy_width    (copy_width),
    .dest_x        (dest_x),
    .dest_y        (dest_y)
  );

endmodule

[hdl/btl_ram.sv]
// Generic simple dual-port RAM with registered read.
module btl_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hdl/btl_fetch.sv]
// Input decode, glyph table and table read stage.
module btl_fetch #(
  parameter int GLYPH_SLOTS = 256
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          action,
  input  logic [7:0]          glyph_index,
  input  logic [11:0]         strip_x,
  input  logic [7:0]          strip_width,
  input  logic signed [15:0]  start_x,
  input  logic signed [15:0]  start_y,
  input  logic [7:0]          char_code,
  input  logic                hold,
  output logic                s1_valid,
  output btl_pkg::op_t        s1_op,
  output logic [11:0]         glyph_pos,
  output logic [7:0]          glyph_width
);

  localparam int AW = $clog2(GLYPH_SLOTS);

  logic                   accept;
  logic                   is_char;
  logic                   fwd;
  logic [7:0]             slot;
  btl_pkg::op_t           op_next;
  logic                   wr_en;
  logic                   rd_en;
  logic                   rd_ok;
  logic [GLYPH_SLOTS-1:0] written;
  logic [19:0]            rd_word;

  assign in_stall = hold;
  assign accept   = in_valid && !hold;
  assign is_char  = (action == btl_pkg::ACT_CHAR);

  // Classify the item and pick the table slot
  always_comb begin
    fwd             = 1'b0;
    slot            = 8'd0;
    op_next.kind    = btl_pkg::KIND_START;
    op_next.start_x = start_x;
    op_next.start_y = start_y;
    if (action == btl_pkg::ACT_START) begin
      fwd = 1'b1;
    end else if (is_char) begin
      if (char_code == btl_pkg::CODE_NEWLINE) begin
        fwd          = 1'b1;
        op_next.kind = btl_pkg::KIND_NEWLINE;
      end else if (char_code == btl_pkg::CODE_SPACE) begin
        fwd          = 1'b1;
        op_next.kind = btl_pkg::KIND_SPACE;
      end else if (char_code >= btl_pkg::FIRST_PRINTABLE &&
                   char_code <= btl_pkg::LAST_LOW_PRINTABLE) begin
        fwd          = 1'b1;
        op_next.kind = btl_pkg::KIND_GLYPH;
        slot         = char_code - btl_pkg::FIRST_PRINTABLE;
      end else if (char_code >= btl_pkg::FIRST_HIGH_PRINTABLE) begin
        fwd          = 1'b1;
        op_next.kind = btl_pkg::KIND_GLYPH;
        slot         = char_code - btl_pkg::FIRST_PRINTABLE - btl_pkg::HIGH_SHIFT;
      end
    end
  end

  assign wr_en = accept && (action == btl_pkg::ACT_GLYPH_WRITE) &&
                 ({1'b0, glyph_index} < 9'(GLYPH_SLOTS));
  assign rd_en = accept && is_char;

  btl_ram #(
    .WIDTH(20),
    .DEPTH(GLYPH_SLOTS)
  ) u_table (
    .clk  (clk),
    .we   (wr_en),
    .waddr(glyph_index[AW-1:0]),
    .wdata({strip_x, strip_width}),
    .re   (rd_en),
    .raddr(slot[AW-1:0]),
    .rdata(rd_word)
  );

  // Entries never written read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
      rd_ok   <= 1'b0;
    end else begin
      if (wr_en) begin
        written[glyph_index[AW-1:0]] <= 1'b1;
      end
      if (rd_en) begin
        rd_ok <= ({1'b0, slot} < 9'(GLYPH_SLOTS)) && written[slot[AW-1:0]];
      end
    end
  end

  assign glyph_pos   = rd_ok ? rd_word[19:8] : 12'd0;
  assign glyph_width = rd_ok ? rd_word[7:0]  : 8'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!hold) begin
      s1_valid <= accept && fwd;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op <= op_next;
    end
  end

endmodule

[hdl/btl_pen.sv]
// Pen update, clipping and output register.
module btl_pen (
  input  logic                clk,
  input  logic                rst,
  input  logic                s1_valid,
  input  btl_pkg::op_t        s1_op,
  input  logic [11:0]         glyph_pos,
  input  logic [7:0]          glyph_width,
  input  logic [7:0]          letter_spacing,
  input  logic [7:0]          line_spacing,
  input  logic [7:0]          line_height,
  input  logic [11:0]         dest_width,
  input  logic [11:0]         dest_height,
  output logic                hold,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [11:0]         source_x,
  output logic [7:0]          copy_width,
  output logic signed [15:0]  dest_x,
  output logic signed [15:0]  dest_y
);

  logic [15:0] pen_x;
  logic [15:0] pen_y;
  logic [15:0] line_start_x;
  logic [15:0] pen_x_next;
  logic [15:0] pen_y_next;
  logic [15:0] line_start_x_next;
  logic [15:0] advance;
  logic        clipped;
  logic        fire;
  logic        emit;
  logic        out_valid_next;

  assign hold = s1_valid && out_valid && out_stall;
  assign fire = s1_valid && !hold;

  assign advance = pen_x + {8'd0, glyph_width} + {{8{letter_spacing[7]}}, letter_spacing};
  assign clipped = ($signed(pen_x) >= $signed({4'd0, dest_width})) ||
                   ($signed(pen_y) >= $signed({4'd0, dest_height}));

  always_comb begin
    pen_x_next        = pen_x;
    pen_y_next        = pen_y;
    line_start_x_next = line_start_x;
    emit              = 1'b0;
    unique case (s1_op.kind)
      btl_pkg::KIND_START: begin
        pen_x_next        = s1_op.start_x;
        line_start_x_next = s1_op.start_x;
        pen_y_next        = s1_op.start_y;
      end
      btl_pkg::KIND_NEWLINE: begin
        pen_x_next = line_start_x;
        pen_y_next = pen_y + {8'd0, line_height} + {{8{line_spacing[7]}}, line_spacing};
      end
      btl_pkg::KIND_SPACE: begin
        pen_x_next = advance;
      end
      btl_pkg::KIND_GLYPH: begin
        if (!clipped) begin
          emit       = 1'b1;
          pen_x_next = advance;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pen_x        <= '0;
      pen_y        <= '0;
      line_start_x <= '0;
    end else if (fire) begin
      pen_x        <= pen_x_next;
      pen_y        <= pen_y_next;
      line_start_x <= line_start_x_next;
    end
  end

  // Hold a beat until taken, load a new one behind it
  assign out_valid_next = (fire && emit) || (out_valid && out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && emit) begin
      source_x   <= glyph_pos;
      copy_width <= glyph_width;
      dest_x     <= pen_x;
      dest_y     <= pen_y;
    end
  end

endmodule

[verif/bitmap_text_layout_tb.sv]
// Self-checking testbench for the bitmap text layout engine.
module bitmap_text_layout_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int GLYPH_SLOTS = 256;
  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 4;
  localparam int QUIET_LIMIT = 3000;
  localparam int LONG_HOLD = 200;
  localparam int SEGMENT_ITEMS = 220;

  typedef struct {
    logic [1:0]         action;
    logic [7:0]         glyph_index;
    logic [11:0]        strip_x;
    logic [7:0]         strip_width;
    logic signed [15:0] start_x;
    logic signed [15:0] start_y;
    logic [7:0]         char_code;
  } text_item_t;

  typedef struct {
    logic [11:0]        source_x;
    logic [7:0]         copy_width;
    logic signed [15:0] dest_x;
    logic signed [15:0] dest_y;
  } blit_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_addr = '0;
  logic [11:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] action = '0;
  logic [7:0] glyph_index = '0;
  logic [11:0] strip_x = '0;
  logic [7:0] strip_width = '0;
  logic signed [15:0] start_x = '0;
  logic signed [15:0] start_y = '0;
  logic [7:0] char_code = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [11:0] source_x;
  logic [7:0] copy_width;
  logic signed [15:0] dest_x;
  logic signed [15:0] dest_y;

  // Layout settings and pen state as the block should hold them
  logic signed [7:0] letter_gap = '0;
  logic signed [7:0] line_gap = '0;
  logic [7:0] line_h = '0;
  logic [11:0] clip_w = '0;
  logic [11:0] clip_h = '0;
  logic [15:0] pen_x = '0;
  logic [15:0] pen_y = '0;
  logic [15:0] line_x = '0;
  logic [11:0] glyph_pos [GLYPH_SLOTS] = '{default: '0};
  logic [7:0] glyph_w [GLYPH_SLOTS] = '{default: '0};

  text_item_t item_q[$];
  blit_t blit_q[$];
  text_item_t cur_item;
  bit in_fire = 1'b0;
  int queued_count = 0;
  int taken_count = 0;
  int mismatch_count = 0;
  int quiet_cycles = 0;
  int tx_idle_pct = 9;
  int rx_idle_pct = 56;
  int hold_ticket = 0;
  int hold_seen = 0;
  int hold_left = 0;

  bitmap_text_layout #(.GLYPH_SLOTS(GLYPH_SLOTS)) uut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Move the pen for one accepted beat and queue the blit it draws, if any.
  function automatic void advance_pen(text_item_t it);
    int slot;
    logic [7:0] w;
    blit_t b;
    case (it.action)
      btl_pkg::ACT_GLYPH_WRITE: begin
        if (it.glyph_index < GLYPH_SLOTS) begin
          glyph_pos[it.glyph_index] = it.strip_x;
          glyph_w[it.glyph_index] = it.strip_width;
        end
      end
      btl_pkg::ACT_START: begin
        pen_x = it.start_x;
        line_x = it.start_x;
        pen_y = it.start_y;
      end
      btl_pkg::ACT_CHAR: begin
        if (it.char_code == btl_pkg::CODE_NEWLINE) begin
          pen_x = line_x;
          pen_y = pen_y + {8'd0, line_h} + {{8{line_gap[7]}}, line_gap};
        end else if (it.char_code == btl_pkg::CODE_SPACE) begin
          pen_x = pen_x + {8'd0, glyph_w[0]} + {{8{letter_gap[7]}}, letter_gap};
        end else if (it.char_code >= btl_pkg::FIRST_PRINTABLE &&
                     (it.char_code <= btl_pkg::LAST_LOW_PRINTABLE ||
                      it.char_code >= btl_pkg::FIRST_HIGH_PRINTABLE) &&
                     int'($signed(pen_x)) < int'(clip_w) &&
                     int'($signed(pen_y)) < int'(clip_h)) begin
          slot = it.char_code - btl_pkg::FIRST_PRINTABLE;
          if (it.char_code >= btl_pkg::FIRST_HIGH_PRINTABLE) slot -= btl_pkg::HIGH_SHIFT;
          w = (slot < GLYPH_SLOTS) ? glyph_w[slot] : 8'd0;
          b.source_x = (slot < GLYPH_SLOTS) ? glyph_pos[slot] : 12'd0;
          b.copy_width = w;
          b.dest_x = pen_x;
          b.dest_y = pen_y;
          blit_q.push_back(b);
          pen_x = pen_x + {8'd0, w} + {{8{letter_gap[7]}}, letter_gap};
        end
      end
      default: ;
    endcase
  endfunction

  task automatic check_field(string name, logic signed [16:0] want, logic signed [16:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  // Monitor, predictor and watchdog
  always @(posedge clk) begin
    blit_t want;
    if (!rst && out_valid && !out_stall) begin
      if (blit_q.size() == 0) begin
        $error("unexpected blit: dest_x %0d, dest_y %0d", dest_x, dest_y);
        mismatch_count++;
      end else begin
        want = blit_q.pop_front();
        check_field("source_x", want.source_x, source_x);
        check_field("copy_width", want.copy_width, copy_width);
        check_field("dest_x", want.dest_x, dest_x);
        check_field("dest_y", want.dest_y, dest_y);
      end
    end
    in_fire = !rst && in_valid && !in_stall;
    if (in_fire) begin
      advance_pen(cur_item);
      taken_count++;
    end
    if (in_fire || (!rst && out_valid && !out_stall)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Driver: hold a stalled beat, otherwise offer the next one or idle.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (item_q.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
        cur_item = item_q.pop_front();
        in_valid <= 1'b1;
        action <= cur_item.action;
        glyph_index <= cur_item.glyph_index;
        strip_x <= cur_item.strip_x;
        strip_width <= cur_item.strip_width;
        start_x <= cur_item.start_x;
        start_y <= cur_item.start_y;
        char_code <= cur_item.char_code;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver stalls; a new hold ticket starts one long stretch.
  always @(negedge clk) begin
    if (hold_seen != hold_ticket) begin
      hold_seen = hold_ticket;
      hold_left = LONG_HOLD;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
    end
  end

  function automatic void queue_item(text_item_t it);
    item_q.push_back(it);
    queued_count++;
  endfunction

  function automatic text_item_t noise_item();
    text_item_t it;
    it.action = 2'($urandom);
    it.glyph_index = 8'($urandom);
    it.strip_x = 12'($urandom);
    it.strip_width = 8'($urandom);
    it.start_x = 16'($urandom);
    it.start_y = 16'($urandom);
    it.char_code = 8'($urandom);
    return it;
  endfunction

  function automatic void load_glyph(logic [7:0] idx, logic [11:0] x, logic [7:0] w);
    text_item_t it;
    it = noise_item();
    it.action = btl_pkg::ACT_GLYPH_WRITE;
    it.glyph_index = idx;
    it.strip_x = x;
    it.strip_width = w;
    queue_item(it);
  endfunction

  function automatic void place_pen(logic signed [15:0] x, logic signed [15:0] y);
    text_item_t it;
    it = noise_item();
    it.action = btl_pkg::ACT_START;
    it.start_x = x;
    it.start_y = y;
    queue_item(it);
  endfunction

  function automatic void type_char(logic [7:0] code);
    text_item_t it;
    it = noise_item();
    it.action = btl_pkg::ACT_CHAR;
    it.char_code = code;
    queue_item(it);
  endfunction

  // Mostly text lines with a few table loads, pen starts and stray beats.
  function automatic text_item_t random_text_item();
    text_item_t it;
    int pick;
    it = noise_item();
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      it.action = btl_pkg::ACT_GLYPH_WRITE;
    end else if (pick < 18) begin
      it.action = btl_pkg::ACT_START;
      if ($urandom_range(0, 3) != 0) begin
        it.start_x = 16'(int'($urandom_range(0, clip_w + 64)) - 32);
        it.start_y = 16'(int'($urandom_range(0, clip_h + 64)) - 32);
      end
    end else if (pick < 20) begin
      it.action = ACT_UNUSED;
    end else begin
      it.action = btl_pkg::ACT_CHAR;
      pick = $urandom_range(0, 99);
      if (pick < 70)
        it.char_code = $urandom_range(0, 1) ? 8'($urandom_range(33, 126))
                                            : 8'($urandom_range(161, 255));
      else if (pick < 78) it.char_code = btl_pkg::CODE_SPACE;
      else if (pick < 86) it.char_code = btl_pkg::CODE_NEWLINE;
    end
    return it;
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [11:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= value;
    case (idx)
      btl_pkg::REG_LETTER_SPACING: letter_gap = value[7:0];
      btl_pkg::REG_LINE_SPACING:   line_gap = value[7:0];
      btl_pkg::REG_LINE_HEIGHT:    line_h = value[7:0];
      btl_pkg::REG_DEST_WIDTH:     clip_w = value;
      btl_pkg::REG_DEST_HEIGHT:    clip_h = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_layout(int ls, int lsp, int lh, int dw, int dh);
    write_reg(btl_pkg::REG_LETTER_SPACING, 12'(ls));
    write_reg(btl_pkg::REG_LINE_SPACING, 12'(lsp));
    write_reg(btl_pkg::REG_LINE_HEIGHT, 12'(lh));
    write_reg(btl_pkg::REG_DEST_WIDTH, 12'(dw));
    write_reg(btl_pkg::REG_DEST_HEIGHT, 12'(dh));
  endtask

  // Wait for every beat to go in and every blit to come out, then let the
  // pipeline settle on beats that draw nothing.
  task automatic drain();
    while (taken_count != queued_count || blit_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic run_segment(int tx_pct, int rx_pct, bit long_hold);
    @(posedge clk);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    if (long_hold) hold_ticket++;
    repeat (SEGMENT_ITEMS / 2) queue_item(random_text_item());
    // sender holds back here until every blit is out
    drain();
    @(posedge clk);
    repeat (SEGMENT_ITEMS - SEGMENT_ITEMS / 2) queue_item(random_text_item());
    drain();
  endtask

  initial begin
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    set_layout(2, -3, 16, 200, 100);

    @(posedge clk);
    load_glyph(8'd0, 12'd0, 8'd5);        // space width and the first printable
    load_glyph(8'd93, 12'd1234, 8'd7);    // last low printable
    load_glyph(8'd94, 12'd2000, 8'd9);    // first high printable
    load_glyph(8'd188, 12'd4095, 8'd255); // code 255
    load_glyph(8'd255, 12'd4095, 8'd255);
    begin
      text_item_t stray;
      stray = noise_item();
      stray.action = ACT_UNUSED;
      queue_item(stray);
    end
    place_pen(16'sd10, 16'sd20);
    type_char(btl_pkg::FIRST_PRINTABLE);
    type_char(btl_pkg::LAST_LOW_PRINTABLE);
    type_char(btl_pkg::FIRST_HIGH_PRINTABLE);
    type_char(8'd255);
    type_char(btl_pkg::CODE_SPACE);
    type_char(btl_pkg::CODE_NEWLINE);
    type_char(8'd0);
    type_char(8'd127);
    type_char(8'd160);
    type_char(8'd65);                     // never loaded, draws zero width
    place_pen(16'sd150, 16'sd99);
    type_char(btl_pkg::FIRST_PRINTABLE);
    type_char(btl_pkg::CODE_NEWLINE);     // drops below the clip height
    type_char(btl_pkg::FIRST_PRINTABLE);
    place_pen(16'sd200, 16'sd0);          // right on the clip width
    type_char(btl_pkg::FIRST_PRINTABLE);
    place_pen(16'sd32765, -16'sd5);
    type_char(btl_pkg::CODE_SPACE);       // x wraps to negative
    type_char(btl_pkg::LAST_LOW_PRINTABLE);
    place_pen(-16'sd32768, 16'sd32760);
    type_char(btl_pkg::CODE_NEWLINE);     // y wraps to negative
    type_char(btl_pkg::FIRST_PRINTABLE);
    drain();

    set_layout(0, 0, 12, 4095, 4095);
    run_segment(9, 56, 1'b0);
    set_layout(-128, 127, 255, 640, 480);
    run_segment(9, 56, 1'b0);
    set_layout(127, -128, 0, 4095, 4095);
    run_segment(56, 9, 1'b0);
    set_layout(-1, 3, 8, 0, 4095);
    run_segment(56, 9, 1'b0);
    set_layout(1, -1, 10, 320, 0);
    run_segment(0, 0, 1'b1);
    set_layout(int'($urandom_range(0, 255)) - 128, int'($urandom_range(0, 255)) - 128,
               $urandom_range(0, 255), $urandom_range(0, 4095), $urandom_range(0, 4095));
    run_segment(0, 0, 1'b0);

    if (mismatch_count == 0 && blit_q.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
